// ===== rtl/core/mrc_pkg.sv =====
package mrc_pkg;

  // Frame and field sizing
  localparam int MAX_FRAME = 128;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int LEN_W     = 8;
  localparam int TMO_W     = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0]      CRC_INIT = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY = 16'hA001;
  localparam logic [TMO_W-1:0] IDLE_MAX = {TMO_W{1'b1}};
  localparam logic [TMO_W-1:0] TMO_RST  = TMO_W'(50000);

  // Input item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_RSP  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result kinds
  localparam logic OUT_TX   = 1'b0;
  localparam logic OUT_DONE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_EN  = 2'd2;

  // One result beat
  typedef struct packed {
    logic             out_kind;
    logic [7:0]       tx_byte;
    logic             tx_last;
    logic [LEN_W-1:0] rx_length;
    logic             timed_out;
    logic             crc_ok;
  } mrc_res_t;

  // What one processed item hands to the output stage
  typedef struct packed {
    logic        vld;
    mrc_res_t    res;
    logic        tail;
    logic [15:0] tail_crc;
  } mrc_evt_t;

  // One byte of CRC-16/MODBUS, bit by bit, LSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrc_engine.sv =====
module mrc_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             fire,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       data_byte,
  input  logic                             last,
  output mrc_pkg::mrc_evt_t                evt
);
  import mrc_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_SEND = 3'b010,
    MODE_WAIT = 3'b100
  } mode_t;

  logic [LEN_W-1:0] exp_len_r;
  logic [TMO_W-1:0] timeout_r;
  logic             crc_en_r;

  mode_t            mode_r, mode_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TMO_W-1:0] idle_r, idle_nxt;
  logic [7:0]       rec0_r, rec0_nxt;
  logic [7:0]       rec1_r, rec1_nxt;

  logic [15:0]      crc_cmd;
  logic [15:0]      crc_rsp;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] limit;
  logic [TMO_W-1:0] idle_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      timeout_r <= TMO_RST;
      crc_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXP_LEN: exp_len_r <= cfg_data[LEN_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_data[TMO_W-1:0];
        CFG_CRC_EN:  crc_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Datapath helpers shared by the item decode below
  assign crc_cmd  = crc_step((mode_r == MODE_SEND) ? crc_r : CRC_INIT, data_byte);
  assign crc_rsp  = (cnt_r >= CNT_W'(2)) ? crc_step(crc_r, rec1_r) : crc_r;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign limit    = (exp_len_r == '0 || 32'(exp_len_r) > MAX_FRAME) ?
                    CNT_W'(MAX_FRAME) : CNT_W'(exp_len_r);
  assign idle_inc = (idle_r != IDLE_MAX) ? idle_r + TMO_W'(1) : idle_r;

  // Item decode: next state and the result it causes
  always_comb begin
    mode_nxt = mode_r;
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    idle_nxt = idle_r;
    rec0_nxt = rec0_r;
    rec1_nxt = rec1_r;
    evt      = '0;
    if (fire) begin
      case (kind)
        KIND_CMD: begin
          evt.vld             = 1'b1;
          evt.res.out_kind    = OUT_TX;
          evt.res.tx_byte     = data_byte;
          evt.res.tx_last     = last && !crc_en_r;
          if (last) begin
            evt.tail     = crc_en_r;
            evt.tail_crc = crc_cmd;
            mode_nxt     = MODE_WAIT;
            crc_nxt      = CRC_INIT;
            cnt_nxt      = '0;
            idle_nxt     = '0;
            rec0_nxt     = '0;
            rec1_nxt     = '0;
          end else begin
            mode_nxt = MODE_SEND;
            crc_nxt  = crc_cmd;
          end
        end
        KIND_RSP: begin
          if (mode_r == MODE_WAIT) begin
            crc_nxt  = crc_rsp;
            rec1_nxt = rec0_r;
            rec0_nxt = data_byte;
            cnt_nxt  = cnt_inc;
            idle_nxt = '0;
            if (cnt_inc >= limit) begin
              evt.vld           = 1'b1;
              evt.res.out_kind  = OUT_DONE;
              evt.res.rx_length = LEN_W'(cnt_inc);
              evt.res.crc_ok    = crc_en_r && (cnt_inc >= CNT_W'(3)) &&
                                  (crc_rsp[7:0] == rec0_r) && (crc_rsp[15:8] == data_byte);
              mode_nxt          = MODE_IDLE;
            end
          end
        end
        KIND_TICK: begin
          if (mode_r == MODE_WAIT) begin
            idle_nxt = idle_inc;
            if (idle_inc >= timeout_r) begin
              evt.vld           = 1'b1;
              evt.res.out_kind  = OUT_DONE;
              evt.res.rx_length = LEN_W'(cnt_r);
              evt.res.timed_out = 1'b1;
              evt.res.crc_ok    = crc_en_r && (cnt_r >= CNT_W'(3)) &&
                                  (crc_r[7:0] == rec1_r) && (crc_r[15:8] == rec0_r);
              mode_nxt          = MODE_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      crc_r  <= CRC_INIT;
      cnt_r  <= '0;
      idle_r <= '0;
      rec0_r <= '0;
      rec1_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      idle_r <= idle_nxt;
      rec0_r <= rec0_nxt;
      rec1_r <= rec1_nxt;
    end
  end

  // A command byte always yields a transmit beat.
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && kind == KIND_CMD) |-> (evt.vld && evt.res.out_kind == OUT_TX))
    else $error("command byte produced no transmit beat");

  // The CRC tail only follows a last command byte with CRC enabled.
  a_tail_src: assert property (@(posedge clk) disable iff (!rst_n)
    evt.tail |-> (evt.vld && last && crc_en_r && kind == KIND_CMD))
    else $error("CRC tail requested outside a closing command byte");

  // A window never counts past the frame limit; the length register may
  // shrink under an open window, so only the frame size bounds the count.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_WAIT) |-> (cnt_r < CNT_W'(MAX_FRAME)))
    else $error("open window holds a full count");

endmodule

// ===== rtl/core/mrc_out.sv =====
module mrc_out (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mrc_pkg::mrc_evt_t       evt,
  output logic                    take_ok,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic [7:0]              out_tx_byte,
  output logic                    out_tx_last,
  output logic [mrc_pkg::LEN_W-1:0] out_rx_length,
  output logic                    out_timed_out,
  output logic                    out_crc_ok
);
  import mrc_pkg::*;

  logic        vld_r, vld_nxt;
  logic [1:0]  tail_cnt_r, tail_cnt_nxt;
  logic [15:0] tail_crc_r, tail_crc_nxt;
  mrc_res_t    res_r, res_nxt;
  logic        slot_free;

  assign slot_free = !vld_r || out_ready;
  assign take_ok   = slot_free && (tail_cnt_r == 2'd0);

  // Result register loading: pending CRC bytes go first, then new results
  always_comb begin
    vld_nxt      = vld_r;
    tail_cnt_nxt = tail_cnt_r;
    tail_crc_nxt = tail_crc_r;
    res_nxt      = res_r;
    if (slot_free) begin
      if (tail_cnt_r != 2'd0) begin
        vld_nxt           = 1'b1;
        res_nxt           = '0;
        res_nxt.out_kind  = OUT_TX;
        res_nxt.tx_byte   = (tail_cnt_r == 2'd2) ? tail_crc_r[7:0] : tail_crc_r[15:8];
        res_nxt.tx_last   = (tail_cnt_r == 2'd1);
        tail_cnt_nxt      = tail_cnt_r - 2'd1;
      end else if (evt.vld) begin
        vld_nxt = 1'b1;
        res_nxt = evt.res;
        if (evt.tail) begin
          tail_cnt_nxt = 2'd2;
          tail_crc_nxt = evt.tail_crc;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      tail_cnt_r <= 2'd0;
    end else begin
      vld_r      <= vld_nxt;
      tail_cnt_r <= tail_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    tail_crc_r <= tail_crc_nxt;
  end

  assign out_valid     = vld_r;
  assign out_kind      = res_r.out_kind;
  assign out_tx_byte   = res_r.tx_byte;
  assign out_tx_last   = res_r.tx_last;
  assign out_rx_length = res_r.rx_length;
  assign out_timed_out = res_r.timed_out;
  assign out_crc_ok    = res_r.crc_ok;

  // Pending CRC bytes always sit behind a beat in the result register.
  a_tail_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != 2'd0) |-> vld_r)
    else $error("CRC tail pending with an empty result register");

  // The high CRC byte closes the request.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r == 2'd1 && slot_free) |=> (vld_r && res_r.tx_last))
    else $error("final CRC byte not marked last");

  // No new item is taken while CRC bytes are still owed.
  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != 2'd0) |-> !evt.vld)
    else $error("result arrived while CRC tail pending");

endmodule

// ===== rtl/core/modbus_rtu_crc_link.sv =====
// An accepted beat waits in the input register until it is processed, which loads
// its first result into the result register; out_valid comes from that register.
// Throughput: one input beat per cycle while the result register is free; a last
// command byte with CRC enabled adds two CRC beats, and the input waits while they
// are sent. Items with no result (ticks, stray bytes) still pass the same way.
// Reset (rst_n low, synchronous) empties both registers, opens no window and
// loads the default configuration: no CRC, full-size frame, 50000-tick timeout.
module modbus_rtu_crc_link (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [7:0]                       out_tx_byte,
  output logic                             out_tx_last,
  output logic [mrc_pkg::LEN_W-1:0]        out_rx_length,
  output logic                             out_timed_out,
  output logic                             out_crc_ok
);
  import mrc_pkg::*;

  logic       in_vld_r;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take_ok;
  logic       fire;
  mrc_evt_t   evt;

  assign fire     = in_vld_r && take_ok;
  assign in_ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r <= in_kind;
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  mrc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .kind      (kind_r),
    .data_byte (byte_r),
    .last      (last_r),
    .evt       (evt)
  );

  mrc_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt           (evt),
    .take_ok       (take_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_tx_last   (out_tx_last),
    .out_rx_length (out_rx_length),
    .out_timed_out (out_timed_out),
    .out_crc_ok    (out_crc_ok)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mrc_pkg::*;

  localparam int     HALF_NS     = 6;
  localparam int     RST_CYCLES  = 11;
  localparam int     RAND_ITEMS  = 500;
  localparam int     MAX_SHOWN   = 10;
  localparam int     HOLD_AT     = 150;
  localparam int     HOLD_CYCLES = 400;
  localparam int     SETTLE      = 8;
  localparam longint LIMIT_NS    = 64'd12_000_000;

  // The one input kind the block does not use.
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef enum logic [2:0] {
    LINK_IDLE = 3'b001,
    LINK_SEND = 3'b010,
    LINK_WAIT = 3'b100
  } link_mode_t;
  typedef enum int { RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE } rx_pattern_t;

  // One line of the directed stimulus: a register write or an input beat.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [1:0]           kind;
    logic [7:0]           data;
    logic                 last;
    logic                 typed;
    mrc_res_t             beat;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_kind = KIND_TICK;
  logic [7:0]           in_data_byte = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  logic [7:0]           out_tx_byte;
  logic                 out_tx_last;
  logic [LEN_W-1:0]     out_rx_length;
  logic                 out_timed_out;
  logic                 out_crc_ok;

  // Link model state and its copy of the registers.
  logic [LEN_W-1:0] exp_len_cfg = '0;
  logic [TMO_W-1:0] tmo_cfg = TMO_RST;
  logic             crc_en_cfg = 1'b0;
  link_mode_t       link_mode = LINK_IDLE;
  logic [15:0]      crc_acc = CRC_INIT;
  int unsigned      rx_count = 0;
  logic [TMO_W-1:0] idle_ticks = '0;
  logic [7:0]       rx_newest = '0;
  logic [7:0]       rx_older = '0;

  mrc_res_t    beats_due[$];
  plan_row_t   plan[$];
  int unsigned burst_left = 0;
  int unsigned live_items = 0;
  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;

  modbus_rtu_crc_link DUT (.*);

  always #(HALF_NS) clk = ~clk;

  // CRC-16/MODBUS over one byte, shifting out the LSB each round.
  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic mrc_res_t tx_beat(logic [7:0] b, logic lst);
    mrc_res_t r;
    r = '0;
    r.out_kind = OUT_TX;
    r.tx_byte = b;
    r.tx_last = lst;
    return r;
  endfunction

  function automatic mrc_res_t done_beat(logic [LEN_W-1:0] len, logic tout, logic ok);
    mrc_res_t r;
    r = '0;
    r.out_kind = OUT_DONE;
    r.rx_length = len;
    r.timed_out = tout;
    r.crc_ok = ok;
    return r;
  endfunction

  // Response bytes that close the window; zero or oversize means a full frame.
  function automatic int unsigned window_cap();
    return (exp_len_cfg == 0 || exp_len_cfg > MAX_FRAME) ? MAX_FRAME : exp_len_cfg;
  endfunction

  // The CRC covers all bytes but the two newest, which must hold it low byte first.
  function automatic void close_window(logic tout);
    logic ok;
    ok = crc_en_cfg && rx_count >= 3 && crc_acc[7:0] == rx_older &&
         crc_acc[15:8] == rx_newest;
    beats_due.push_back(done_beat(LEN_W'(rx_count), tout, ok));
    link_mode = LINK_IDLE;
  endfunction

  // Advance the link by one accepted beat and queue the results it causes.
  // Returns 1 when the beat did anything at all.
  function automatic bit advance_link(logic [1:0] kind, logic [7:0] b, logic lst);
    bit active;
    active = 1'b0;
    case (kind)
      KIND_CMD: begin
        active = 1'b1;
        if (link_mode != LINK_SEND) begin
          crc_acc = CRC_INIT;
          link_mode = LINK_SEND;
        end
        crc_acc = crc16_modbus_byte(crc_acc, b);
        beats_due.push_back(tx_beat(b, lst && !crc_en_cfg));
        if (lst) begin
          if (crc_en_cfg) begin
            beats_due.push_back(tx_beat(crc_acc[7:0], 1'b0));
            beats_due.push_back(tx_beat(crc_acc[15:8], 1'b1));
          end
          link_mode = LINK_WAIT;
          crc_acc = CRC_INIT;
          rx_count = 0;
          idle_ticks = '0;
          rx_newest = '0;
          rx_older = '0;
        end
      end
      KIND_RSP: begin
        if (link_mode == LINK_WAIT) begin
          active = 1'b1;
          if (rx_count >= 2) crc_acc = crc16_modbus_byte(crc_acc, rx_older);
          rx_older = rx_newest;
          rx_newest = b;
          rx_count++;
          idle_ticks = '0;
          if (rx_count >= window_cap()) close_window(1'b0);
        end
      end
      KIND_TICK: begin
        if (link_mode == LINK_WAIT) begin
          active = 1'b1;
          if (idle_ticks != IDLE_MAX) idle_ticks++;
          if (idle_ticks >= tmo_cfg) close_window(1'b1);
        end
      end
      default: ;
    endcase
    return active;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [1:0] kind, logic [7:0] d, logic lst,
                                          mrc_res_t beat);
    plan_row_t r;
    r = '0;
    r.kind = kind;
    r.data = d;
    r.last = lst;
    r.typed = 1'b1;
    r.beat = beat;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] kind, logic [7:0] d, logic lst);
    plan_row_t r;
    r = known_row(kind, d, lst, '0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic void flag_mismatch(string what, mrc_res_t want, mrc_res_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t: %s: expected kind %0d byte %02h last %0d len %0d tmo %0d crc %0d",
               $time, what, want.out_kind, want.tx_byte, want.tx_last, want.rx_length,
               want.timed_out, want.crc_ok);
      $display("%0t: %s: actual   kind %0d byte %02h last %0d len %0d tmo %0d crc %0d",
               $time, what, got.out_kind, got.tx_byte, got.tx_last, got.rx_length,
               got.timed_out, got.crc_ok);
    end
  endfunction

  // Register write; called at a rising edge, returns at a rising edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EXP_LEN: exp_len_cfg = val[LEN_W-1:0];
      CFG_TIMEOUT: tmo_cfg = val[TMO_W-1:0];
      CFG_CRC_EN:  crc_en_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, let every queued result drain, then allow for beats that
  // caused no result but may still be in flight.
  task automatic settle_link();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one input beat in bursts with random gaps. A typed row replaces
  // the modeled result with the one written in the plan.
  task automatic send_item(logic [1:0] kind, logic [7:0] b, logic lst, logic use_typed,
                           mrc_res_t typed_beat);
    int unsigned n0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 1) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (in_ready !== 1'b1);
    n0 = beats_due.size();
    if (advance_link(kind, b, lst)) live_items++;
    if (use_typed) begin
      while (beats_due.size() > n0) void'(beats_due.pop_back());
      beats_due.push_back(typed_beat);
    end
  endtask

  task automatic offer(logic [1:0] kind, logic [7:0] b, logic lst);
    send_item(kind, b, lst, 1'b0, '0);
  endtask

  // One request and its response, or a short run of noise.
  task automatic run_exchange();
    int unsigned n_cmd;
    int unsigned n_rsp;
    int unsigned cap;
    int unsigned ending;
    int unsigned flip;
    logic [7:0]  body[$];
    logic [15:0] c;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6))
        offer(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      return;
    end
    n_cmd = $urandom_range(1, 6);
    for (int i = 1; i <= n_cmd; i++) offer(KIND_CMD, 8'($urandom), i == n_cmd);

    // Ending: 0 fills the window, 1 times out, 2 leaves it to the next request.
    cap = window_cap();
    ending = $urandom_range(0, 2);
    if (ending == 1 && tmo_cfg > 64) ending = 0;
    if (ending == 0 && cap > 16 && tmo_cfg <= 64 && $urandom_range(0, 7) != 0) ending = 1;
    n_rsp = (ending == 0) ? cap : $urandom_range(0, (cap > 9) ? 8 : cap - 1);

    // Mostly frames with a good CRC, now and then with one bit flipped.
    for (int i = 0; i + 2 < n_rsp; i++) body.push_back(8'($urandom));
    if (n_rsp >= 2 && $urandom_range(0, 3) != 0) begin
      c = CRC_INIT;
      foreach (body[i]) c = crc16_modbus_byte(c, body[i]);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      if ($urandom_range(0, 7) == 0) begin
        flip = $urandom_range(0, n_rsp - 1);
        body[flip] = body[flip] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
    while (body.size() < n_rsp) body.push_back(8'($urandom));

    // Ticks between bytes stay short of the timeout.
    foreach (body[i]) begin
      if (tmo_cfg > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, (tmo_cfg > 6) ? 5 : tmo_cfg - 1))
          offer(KIND_TICK, 8'($urandom), 1'($urandom));
      offer(KIND_RSP, body[i], 1'($urandom));
    end
    if (ending == 1)
      repeat ((tmo_cfg == 0) ? 1 : tmo_cfg) offer(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Result side: a randomly chosen stall pattern, and once, after enough beats,
  // a long stall lets the block fill up.
  rx_pattern_t rx_pattern = RX_OPEN;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held && beats_taken >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case (rx_pattern)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= rx_cycle[2];
      endcase
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_beats
    mrc_res_t got;
    mrc_res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got = {out_kind, out_tx_byte, out_tx_last, out_rx_length, out_timed_out, out_crc_ok};
      beats_taken <= beats_taken + 1;
      if (beats_due.size() == 0) begin
        flag_mismatch("unexpected beat", '0, got);
      end else begin
        want = beats_due.pop_front();
        if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
            got.tx_last !== want.tx_last || got.rx_length !== want.rx_length ||
            got.timed_out !== want.timed_out || got.crc_ok !== want.crc_ok)
          flag_mismatch("wrong beat", want, got);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [7:0]  read_frame[8];
    int unsigned phase;
    int unsigned rounds;

    read_frame = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h84, 8'h0A};

    // Idle link: stray response bytes, ticks and the unused kind do nothing.
    plan.push_back(cfg_row(CFG_EXP_LEN, 2));
    plan.push_back(cfg_row(CFG_TIMEOUT, 0));
    plan.push_back(item_row(KIND_RSP, 8'h55, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'hAA, 1'b1));
    plan.push_back(item_row(KIND_NONE, 8'hFF, 1'b1));
    // One-byte request without CRC; with a zero timeout the first tick closes.
    plan.push_back(known_row(KIND_CMD, 8'hFF, 1'b1, tx_beat(8'hFF, 1'b1)));
    plan.push_back(known_row(KIND_TICK, 8'h00, 1'b0, done_beat(0, 1'b1, 1'b0)));
    // Two-byte request, then a response that fills a two-byte window.
    plan.push_back(known_row(KIND_CMD, 8'h00, 1'b0, tx_beat(8'h00, 1'b0)));
    plan.push_back(known_row(KIND_CMD, 8'h80, 1'b1, tx_beat(8'h80, 1'b1)));
    plan.push_back(item_row(KIND_RSP, 8'h00, 1'b0));
    plan.push_back(known_row(KIND_RSP, 8'hFF, 1'b0, done_beat(2, 1'b0, 1'b0)));
    // CRC on: a read request gets its CRC appended; a new request drops the
    // open window, and a well-formed frame then passes the check.
    plan.push_back(cfg_row(CFG_CRC_EN, 1));
    plan.push_back(cfg_row(CFG_TIMEOUT, 2));
    plan.push_back(cfg_row(CFG_EXP_LEN, 8));
    for (int i = 0; i < 6; i++)
      plan.push_back(item_row(KIND_CMD, read_frame[i], i == 5));
    plan.push_back(item_row(KIND_RSP, 8'h01, 1'b0));
    plan.push_back(item_row(KIND_CMD, 8'h11, 1'b1));
    foreach (read_frame[i]) plan.push_back(item_row(KIND_RSP, read_frame[i], 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'h00, 1'b0));

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_link();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].kind, plan[i].data, plan[i].last, plan[i].typed, plan[i].beat);
      end
    end

    // Random phases; the first few pin the register extremes.
    live_items = 0;
    phase = 0;
    while (live_items < RAND_ITEMS) begin
      settle_link();
      case (phase)
        0: begin
          write_reg(CFG_EXP_LEN, 255);
          write_reg(CFG_TIMEOUT, 3);
          write_reg(CFG_CRC_EN, 0);
        end
        1: begin
          write_reg(CFG_EXP_LEN, CFG_W'(MAX_FRAME));
          write_reg(CFG_TIMEOUT, IDLE_MAX);
          write_reg(CFG_CRC_EN, 1);
        end
        2: begin
          write_reg(CFG_EXP_LEN, 1);
          write_reg(CFG_TIMEOUT, 1);
          write_reg(CFG_CRC_EN, 1);
        end
        3: begin
          write_reg(CFG_EXP_LEN, 0);
          write_reg(CFG_TIMEOUT, 0);
          write_reg(CFG_CRC_EN, 1);
        end
        default: begin
          write_reg(CFG_EXP_LEN, CFG_W'(($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, 255) : $urandom_range(1, 12)));
          write_reg(CFG_TIMEOUT, CFG_W'(($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, 40) : $urandom_range(1, 6)));
          write_reg(CFG_CRC_EN, CFG_W'($urandom_range(0, 1)));
        end
      endcase
      rounds = (phase == 1) ? 2 : $urandom_range(4, 10);
      repeat (rounds) run_exchange();
      phase++;
    end

    settle_link();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
